// ===== hw/rtl/mrpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrpt_pkg - shared types and constants for the primality test core
// Holds the witness and small prime tables and the engine state type.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int WORD_W            = 64;
  localparam int WITNESS_COUNT     = 7;
  localparam int SMALL_PRIME_COUNT = 12;
  localparam int WIT_IDX_W         = 3;
  localparam int SP_IDX_W          = 4;
  localparam int FIFO_DEPTH        = 2;
  localparam int NIB_COUNT         = WORD_W / 4;
  localparam int NIB_CNT_W         = $clog2(NIB_COUNT);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMALL,
    ST_SCHECK,
    ST_DECOMP,
    ST_WRED,
    ST_PMUL,
    ST_PSQR,
    ST_CHECK,
    ST_SQUARE,
    ST_SQCHECK,
    ST_DONE
  } eng_state_t;

  typedef enum logic [1:0] {
    CLS_NOT_PRIME,
    CLS_PRIME,
    CLS_TEST
  } cls_t;

  typedef struct packed {
    cls_t             cls;
    logic [WORD_W-1:0] n;
  } job_t;

  function automatic logic [WORD_W-1:0] witness(input logic [WIT_IDX_W-1:0] i);
    logic [WORD_W-1:0] w;
    w = '0;
    unique case (i)
      3'd0: w = 64'd2;
      3'd1: w = 64'd325;
      3'd2: w = 64'd9375;
      3'd3: w = 64'd28178;
      3'd4: w = 64'd450775;
      3'd5: w = 64'd9780504;
      3'd6: w = 64'd1795265022;
      default: w = 64'd2;
    endcase
    return w;
  endfunction

  function automatic logic [5:0] small_prime(input logic [SP_IDX_W-1:0] i);
    logic [5:0] p;
    p = '0;
    unique case (i)
      4'd0: p = 6'd2;
      4'd1: p = 6'd3;
      4'd2: p = 6'd5;
      4'd3: p = 6'd7;
      4'd4: p = 6'd11;
      4'd5: p = 6'd13;
      4'd6: p = 6'd17;
      4'd7: p = 6'd19;
      4'd8: p = 6'd23;
      4'd9: p = 6'd29;
      4'd10: p = 6'd31;
      4'd11: p = 6'd37;
      default: p = 6'd2;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/mrpt_front.sv =====
// ----------------------------------------------------------------------------
// mrpt_front - input stage
// Accepts numbers and marks those below two as not prime.
// ----------------------------------------------------------------------------
module mrpt_front import mrpt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [WORD_W-1:0] in_number,
  output logic                     job_valid,
  input  logic                     job_stall,
  output job_t                     job
);

  logic valid_r;
  job_t job_r;

  assign in_stall  = valid_r && job_stall;
  assign job_valid = valid_r;
  assign job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      job_r.n <= in_number;
      if (in_number < 64'sd2) begin
        job_r.cls <= CLS_NOT_PRIME;
      end else begin
        job_r.cls <= CLS_TEST;
      end
    end
  end

endmodule

// ===== hw/rtl/mrpt_fifo.sv =====
// ----------------------------------------------------------------------------
// mrpt_fifo - short job queue
// Decouples the front stage from the test engine.
// ----------------------------------------------------------------------------
module mrpt_fifo import mrpt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_stall,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_stall,
  output job_t rd_data
);

  job_t       mem_r [FIFO_DEPTH];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign wr_stall = (cnt_r == 2'(FIFO_DEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rptr_r];
  assign do_wr    = wr_valid && !wr_stall;
  assign do_rd    = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_wr) wptr_r <= ~wptr_r;
      if (do_rd) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

// ===== hw/rtl/mrpt_mulmod.sv =====
// ----------------------------------------------------------------------------
// mrpt_mulmod - shift-and-add modular multiplier
// One multiplier bit per cycle; operands must already be below m.
// ----------------------------------------------------------------------------
module mrpt_mulmod import mrpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] x,
  input  logic [WORD_W-1:0] y,
  input  logic [WORD_W-1:0] m,
  output logic              done,
  output logic [WORD_W-1:0] result
);

  logic              busy_r;
  logic [WORD_W-1:0] acc_r, x_r, y_r;
  logic [WORD_W-1:0] acc_sum, x_dbl;

  always_comb begin
    acc_sum = acc_r + x_r;
    if (acc_sum >= m) acc_sum = acc_sum - m;
    x_dbl = {x_r[WORD_W-2:0], 1'b0};
    if (x_dbl >= m) x_dbl = x_dbl - m;
  end

  assign done   = busy_r && (y_r == '0);
  assign result = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      x_r   <= x;
      y_r   <= y;
    end else if (busy_r && y_r != '0) begin
      if (y_r[0]) acc_r <= acc_sum;
      x_r <= x_dbl;
      y_r <= {1'b0, y_r[WORD_W-1:1]};
    end
  end

endmodule

// ===== hw/rtl/mrpt_engine.sv =====
// ----------------------------------------------------------------------------
// mrpt_engine - test sequencer
// Runs the small prime checks, then the Miller-Rabin rounds on a shared
// modular multiplier, and holds the verdict in an output register.
// ----------------------------------------------------------------------------
module mrpt_engine import mrpt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_stall,
  input  job_t job,
  output logic out_valid,
  input  logic out_stall,
  output logic out_is_prime
);

  eng_state_t                   state_r, state_nxt;
  logic [WORD_W-1:0]            n_r, n_nxt, sh_r, sh_nxt, d_r, d_nxt, e_r, e_nxt;
  logic [WORD_W-1:0]            base_r, base_nxt, acc_r, acc_nxt, x_r, x_nxt, nm1;
  logic [NIB_CNT_W-1:0]         nib_r, nib_nxt;
  logic [5:0]                   s_r, s_nxt, r_r, r_nxt;
  logic [WIT_IDX_W-1:0]         wi_r, wi_nxt;
  logic                         ov_r, ov_nxt, res_r, res_nxt;
  logic                         mm_issued_r, mm_issued_nxt;
  logic                         rem_load, rem_shift;
  logic                         mm_start, mm_done;
  logic [WORD_W-1:0]            mm_x, mm_y, mm_res;
  logic [SMALL_PRIME_COUNT-1:0] sp_hit, sp_zero;

  assign nm1 = n_r - WORD_W'(1);

  // one residue lane per small prime, fed a nibble per cycle from the top
  for (genvar i = 0; i < SMALL_PRIME_COUNT; i++) begin : g_lane
    logic [5:0] sp, rem_r, rem_nxt;
    logic [9:0] v0, v1, v2, v3, v4;

    assign sp = small_prime(SP_IDX_W'(i));

    always_comb begin
      v0 = {rem_r, sh_r[WORD_W-1 -: 4]};
      v1 = (v0 >= {1'b0, sp, 3'b000}) ? v0 - {1'b0, sp, 3'b000} : v0;
      v2 = (v1 >= {2'b00, sp, 2'b00}) ? v1 - {2'b00, sp, 2'b00} : v1;
      v3 = (v2 >= {3'b000, sp, 1'b0}) ? v2 - {3'b000, sp, 1'b0} : v2;
      v4 = (v3 >= {4'b0000, sp}) ? v3 - {4'b0000, sp} : v3;
      rem_nxt = rem_r;
      if (rem_load) begin
        rem_nxt = '0;
      end else if (rem_shift) begin
        rem_nxt = v4[5:0];
      end
    end

    always_ff @(posedge clk) begin
      rem_r <= rem_nxt;
    end

    assign sp_hit[i]  = (n_r == WORD_W'(sp));
    assign sp_zero[i] = (rem_r == 6'd0);
  end

  mrpt_mulmod u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .x      (mm_x),
    .y      (mm_y),
    .m      (n_r),
    .done   (mm_done),
    .result (mm_res)
  );

  assign out_valid    = ov_r;
  assign out_is_prime = res_r;
  assign job_stall    = (state_r != ST_IDLE) || ov_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    sh_nxt        = sh_r;
    nib_nxt       = nib_r;
    d_nxt         = d_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    x_nxt         = x_r;
    r_nxt         = r_r;
    wi_nxt        = wi_r;
    res_nxt       = res_r;
    ov_nxt        = ov_r;
    mm_issued_nxt = mm_issued_r;
    rem_load      = 1'b0;
    rem_shift     = 1'b0;
    mm_start      = 1'b0;
    mm_x          = acc_r;
    mm_y          = base_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid && !ov_r) begin
          n_nxt    = job.n;
          sh_nxt   = job.n;
          nib_nxt  = '0;
          rem_load = 1'b1;
          if (job.cls == CLS_TEST) begin
            state_nxt = ST_SMALL;
          end else begin
            res_nxt = (job.cls == CLS_PRIME);
            ov_nxt  = 1'b1;
          end
        end
      end
      ST_SMALL: begin
        rem_shift = 1'b1;
        sh_nxt    = {sh_r[WORD_W-5:0], 4'h0};
        nib_nxt   = nib_r + 1'b1;
        if (nib_r == NIB_CNT_W'(NIB_COUNT - 1)) state_nxt = ST_SCHECK;
      end
      ST_SCHECK: begin
        if (|sp_hit) begin
          res_nxt = 1'b1; ov_nxt = 1'b1; state_nxt = ST_IDLE;
        end else if (|sp_zero) begin
          res_nxt = 1'b0; ov_nxt = 1'b1; state_nxt = ST_IDLE;
        end else begin
          d_nxt = nm1; s_nxt = '0; state_nxt = ST_DECOMP;
        end
      end
      ST_DECOMP: begin
        if (d_r == '0 || d_r[0] || s_r == 6'd63) begin
          wi_nxt = '0; state_nxt = ST_WRED;
        end else begin
          d_nxt = {1'b0, d_r[WORD_W-1:1]}; s_nxt = s_r + 6'd1;
        end
      end
      ST_WRED: begin
        // reduce the witness mod n as the product 1 * w
        mm_x = WORD_W'(1);
        mm_y = witness(wi_r);
        if (!mm_issued_r) begin
          mm_start = 1'b1; mm_issued_nxt = 1'b1;
        end else if (mm_done) begin
          mm_issued_nxt = 1'b0;
          if (mm_res == '0) begin
            state_nxt = ST_DONE;
          end else begin
            base_nxt = mm_res; acc_nxt = WORD_W'(1); e_nxt = d_r; state_nxt = ST_PMUL;
          end
        end
      end
      ST_PMUL: begin
        // acc *= base when the exponent bit is set, then square base
        if (e_r == '0) begin
          x_nxt = acc_r; r_nxt = 6'd1; state_nxt = ST_CHECK;
        end else if (!e_r[0]) begin
          state_nxt = ST_PSQR;
        end else if (!mm_issued_r) begin
          mm_start = 1'b1; mm_issued_nxt = 1'b1;
        end else if (mm_done) begin
          acc_nxt = mm_res; mm_issued_nxt = 1'b0; state_nxt = ST_PSQR;
        end
      end
      ST_PSQR: begin
        mm_x = base_r;
        mm_y = base_r;
        if (!mm_issued_r) begin
          mm_start = 1'b1; mm_issued_nxt = 1'b1;
        end else if (mm_done) begin
          base_nxt = mm_res; e_nxt = {1'b0, e_r[WORD_W-1:1]};
          mm_issued_nxt = 1'b0; state_nxt = ST_PMUL;
        end
      end
      ST_CHECK: begin
        if (x_r == WORD_W'(1) || x_r == nm1) begin
          state_nxt = ST_DONE;
        end else if (r_r >= s_r) begin
          res_nxt = 1'b0; ov_nxt = 1'b1; state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        mm_x = x_r;
        mm_y = x_r;
        if (!mm_issued_r) begin
          mm_start = 1'b1; mm_issued_nxt = 1'b1;
        end else if (mm_done) begin
          x_nxt = mm_res; mm_issued_nxt = 1'b0; state_nxt = ST_SQCHECK;
        end
      end
      ST_SQCHECK: begin
        if (x_r == nm1) begin
          state_nxt = ST_DONE;
        end else if (x_r == WORD_W'(1) || r_r + 6'd1 >= s_r) begin
          res_nxt = 1'b0; ov_nxt = 1'b1; state_nxt = ST_IDLE;
        end else begin
          r_nxt = r_r + 6'd1; state_nxt = ST_SQUARE;
        end
      end
      ST_DONE: begin
        // witness passed
        if (wi_r == WIT_IDX_W'(WITNESS_COUNT - 1)) begin
          res_nxt = 1'b1; ov_nxt = 1'b1; state_nxt = ST_IDLE;
        end else begin
          wi_nxt = wi_r + 1'b1; state_nxt = ST_WRED;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r        <= 1'b0;
      res_r       <= 1'b0;
      mm_issued_r <= 1'b0;
    end else begin
      ov_r        <= ov_nxt;
      res_r       <= res_nxt;
      mm_issued_r <= mm_issued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    sh_r   <= sh_nxt;
    nib_r  <= nib_nxt;
    d_r    <= d_nxt;
    s_r    <= s_nxt;
    e_r    <= e_nxt;
    base_r <= base_nxt;
    acc_r  <= acc_nxt;
    x_r    <= x_nxt;
    r_r    <= r_nxt;
    wi_r   <= wi_nxt;
  end

endmodule

// ===== hw/rtl/miller_rabin_primality_test_core.sv =====
// ----------------------------------------------------------------------------
// miller_rabin_primality_test_core - 64-bit deterministic primality test
// Reports whether a signed 64-bit number is prime.
// ----------------------------------------------------------------------------
// Usage:
//   Present a number on in_number with in_valid; it is taken at an edge where
//   in_stall is low. One verdict per number comes back on out_is_prime with
//   out_valid, held until out_stall is low.
//   Numbers below two pass the front register and the queue and raise
//   out_valid from the engine's output register; others first run a
//   nibble-serial residue pass against the small primes and finish there
//   when a small prime decides. The rest run up to seven witness rounds on
//   one shift-add modular multiplier. A two-entry queue lets a new number
//   be taken while the engine works; numbers are processed one at a time,
//   the next one starting the cycle after the previous verdict is taken.
//   Reset empties the queue and drops any result in flight. A stalled
//   output holds the engine, which then backs up the queue and the input.
// ----------------------------------------------------------------------------
module miller_rabin_primality_test_core import mrpt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [WORD_W-1:0] in_number,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_is_prime
);

  logic f_valid, f_stall, q_valid, q_stall;
  job_t f_job, q_job;

  mrpt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_number (in_number),
    .job_valid (f_valid),
    .job_stall (f_stall),
    .job       (f_job)
  );

  mrpt_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_stall (f_stall),
    .wr_data  (f_job),
    .rd_valid (q_valid),
    .rd_stall (q_stall),
    .rd_data  (q_job)
  );

  mrpt_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (q_valid),
    .job_stall    (q_stall),
    .job          (q_job),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_prime (out_is_prime)
  );

endmodule
